/* rtl/bfbfs_pkg.sv */
package bfbfs_pkg;

  localparam int BITMAP_WORDS_DEF = 1024;
  localparam int NEAR_SLACK_DEF   = 64;
  localparam logic [10:0] WORDS_IN_USE_RST = 11'd1024;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef logic [63:0] word_t;

  function automatic logic [5:0] ctz64(input word_t v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/bfbfs_ram.sv */
module bfbfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bitmap_free_run_best_fit_search.sv */
// Write words produce no result; busy stays low.
// A search reads each bitmap word scanned, then scans it, and for each free run
// opens it, closes it and evaluates it, with a closing step at the end. The
// first-fit fallback can add a second pass, and the result strobe is registered.
// One search runs at a time: start is taken only while busy is low.
// Synchronous active-low reset idles the sequencer and sets words in use to 1024.
module bitmap_free_run_best_fit_search #(
  parameter int BITMAP_WORDS = bfbfs_pkg::BITMAP_WORDS_DEF,
  parameter int NEAR_SLACK   = bfbfs_pkg::NEAR_SLACK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [9:0]  in_word_index,
  input  logic [63:0] in_word_data,
  input  logic [16:0] in_run_length_needed,
  input  logic [15:0] in_near_bit,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_found,
  output logic [15:0] out_start_page,
  output logic [16:0] out_run_length
);

  localparam int WW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int PW = WW + 7;
  localparam int CW = (PW > 19) ? PW : 19;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [10:0]   words_r;
  logic [WW:0]   cov_r, cov_nxt;
  logic [WW:0]   word_r, word_nxt;
  logic [WW:0]   base_r, base_nxt;
  logic [WW:0]   sword_r, sword_nxt;
  logic [5:0]    p_r, p_nxt;
  logic          in_run_r, in_run_nxt;
  logic          last_r, last_nxt;
  logic          bmode_r, bmode_nxt;
  logic          have_r, have_nxt;
  logic [PW-1:0] rs_r, rs_nxt;
  logic [PW-1:0] re_r, re_nxt;
  logic [PW-1:0] bpos_r, bpos_nxt;
  logic [PW-1:0] blen_r, blen_nxt;
  logic [16:0]   need_r, need_nxt;
  logic          near_nz_r, near_nz_nxt;
  logic          ov_nxt, of_nxt;
  logic [CW-1:0] opos_nxt, olen_nxt;

  logic          acc, ram_we, ram_re;
  bfbfs_pkg::word_t rdata, smask, m;
  logic [5:0]    q;
  logic [CW-1:0] cov_c, sw_c, nw_c, rl_c, dist_c, lim_c;

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;
  assign ram_we = acc && (in_action == bfbfs_pkg::ACT_WRITE) &&
                  (CW'(in_word_index) < CW'(BITMAP_WORDS));
  assign ram_re = (state_r == S_RD);

  bfbfs_ram #(.WIDTH(64), .DEPTH(BITMAP_WORDS), .AW(WW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_word_index[WW-1:0]),
    .wdata (in_word_data),
    .re    (ram_re),
    .raddr (word_r[WW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    cov_nxt     = cov_r;
    word_nxt    = word_r;
    base_nxt    = base_r;
    sword_nxt   = sword_r;
    p_nxt       = p_r;
    in_run_nxt  = in_run_r;
    last_nxt    = last_r;
    bmode_nxt   = bmode_r;
    have_nxt    = have_r;
    rs_nxt      = rs_r;
    re_nxt      = re_r;
    bpos_nxt    = bpos_r;
    blen_nxt    = blen_r;
    need_nxt    = need_r;
    near_nz_nxt = near_nz_r;
    ov_nxt      = 1'b0;
    of_nxt      = 1'b0;
    opos_nxt    = '0;
    olen_nxt    = '0;

    cov_c  = (CW'(words_r) > CW'(BITMAP_WORDS)) ? CW'(BITMAP_WORDS) : CW'(words_r);
    sw_c   = CW'(in_near_bit[15:6]);
    smask  = ~64'd0 << p_r;
    m      = in_run_r ? (rdata & smask) : (~rdata & smask);
    q      = bfbfs_pkg::ctz64(m);
    nw_c   = CW'(word_r) + CW'(1);
    rl_c   = CW'(re_r) - CW'(rs_r);
    dist_c = CW'(rs_r) - (CW'(base_r) << 6);
    lim_c  = CW'(NEAR_SLACK) + CW'(need_r);

    case (state_r)
      S_IDLE: begin
        if (acc && in_action == bfbfs_pkg::ACT_SEARCH) begin
          need_nxt    = in_run_length_needed;
          near_nz_nxt = (in_near_bit != 16'd0);
          cov_nxt     = cov_c[WW:0];
          sword_nxt   = sw_c[WW:0];
          word_nxt    = sw_c[WW:0];
          base_nxt    = sw_c[WW:0];
          p_nxt       = 6'd0;
          in_run_nxt  = 1'b0;
          last_nxt    = 1'b0;
          bmode_nxt   = 1'b1;
          have_nxt    = 1'b0;
          if (in_run_length_needed == 17'd0 || sw_c >= cov_c) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (m == 64'd0) begin
          if (nw_c == CW'(cov_r)) begin
            if (in_run_r) begin
              re_nxt    = PW'(nw_c << 6);
              last_nxt  = 1'b1;
              state_nxt = S_EVAL;
            end else begin
              state_nxt = S_FIN;
            end
          end else begin
            word_nxt  = nw_c[WW:0];
            p_nxt     = 6'd0;
            state_nxt = S_RD;
          end
        end else if (in_run_r) begin
          re_nxt     = PW'({word_r[WW-1:0], q});
          p_nxt      = q;
          in_run_nxt = 1'b0;
          state_nxt  = S_EVAL;
        end else begin
          rs_nxt     = PW'({word_r[WW-1:0], q});
          p_nxt      = q;
          in_run_nxt = 1'b1;
        end
      end
      S_EVAL: begin
        state_nxt = last_r ? S_FIN : S_SCAN;
        if (rl_c >= CW'(need_r)) begin
          if (!bmode_r || rl_c == CW'(need_r)) begin
            ov_nxt    = 1'b1;
            of_nxt    = 1'b1;
            opos_nxt  = CW'(rs_r);
            olen_nxt  = rl_c;
            state_nxt = S_IDLE;
          end else begin
            if (!have_r || rl_c < CW'(blen_r)) begin
              have_nxt = 1'b1;
              blen_nxt = rl_c[PW-1:0];
              bpos_nxt = rs_r;
            end
            if (near_nz_r && dist_c > lim_c) begin
              have_nxt  = 1'b1;
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (have_r) begin
          ov_nxt    = 1'b1;
          of_nxt    = 1'b1;
          opos_nxt  = CW'(bpos_r);
          olen_nxt  = CW'(blen_r);
          state_nxt = S_IDLE;
        end else if (bmode_r && sword_r != '0 && need_r != 17'd0 &&
                     CW'(sword_r) < CW'(cov_r)) begin
          bmode_nxt  = 1'b0;
          word_nxt   = '0;
          base_nxt   = '0;
          p_nxt      = 6'd0;
          in_run_nxt = 1'b0;
          last_nxt   = 1'b0;
          state_nxt  = S_RD;
        end else begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      words_r   <= bfbfs_pkg::WORDS_IN_USE_RST;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= ov_nxt;
      if (cfg_we) begin
        words_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cov_r          <= cov_nxt;
    word_r         <= word_nxt;
    base_r         <= base_nxt;
    sword_r        <= sword_nxt;
    p_r            <= p_nxt;
    in_run_r       <= in_run_nxt;
    last_r         <= last_nxt;
    bmode_r        <= bmode_nxt;
    have_r         <= have_nxt;
    rs_r           <= rs_nxt;
    re_r           <= re_nxt;
    bpos_r         <= bpos_nxt;
    blen_r         <= blen_nxt;
    need_r         <= need_nxt;
    near_nz_r      <= near_nz_nxt;
    out_found      <= of_nxt;
    out_start_page <= opos_nxt[15:0];
    out_run_length <= olen_nxt[16:0];
  end

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_start_page == 16'd0 && out_run_length == 17'd0)
    else $error("miss result not zero");
  a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_run_length != 17'd0)
    else $error("hit with empty run");
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == bfbfs_pkg::ACT_WRITE |=> !busy && !out_valid)
    else $error("write word caused work");
`endif

endmodule
